FILE: rtl/scnh_pkg.sv
// Shared types, constants and the byte-wise CRC-32C function for the name hash block.
package scnh_pkg;

  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] KeyHiSet = 32'h8000_0000;
  localparam logic [15:0] KeyLoTail = 16'h8000;

  localparam logic [7:0] SepDot = 8'h2E;
  localparam logic [7:0] SepDash = 8'h2D;
  localparam logic [7:0] SepUnder = 8'h5F;
  localparam logic [7:0] SepTilde = 8'h7E;

  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  // One classified name byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] name_byte;
    logic       sep;
    logic       last;
  } scnh_item_t;

  // Reflected CRC-32C update by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] r;
    r = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/scnh_front.sv
// Input side: takes name bytes and tags each one as a segment separator or not.
module scnh_front
  import scnh_pkg::*;
(
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] name_byte
  input  logic       s_axis_tlast_i,  // last_byte
  input  logic       q_full_i,
  output logic       q_push_o,
  output scnh_item_t q_item_o
);

  logic is_sep;

  always_comb begin
    is_sep = s_axis_tdata_i inside {SepDot, SepDash, SepUnder, SepTilde};
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_item_o.name_byte = s_axis_tdata_i;
    q_item_o.sep       = is_sep;
    q_item_o.last      = s_axis_tlast_i;
  end

endmodule

FILE: rtl/scnh_queue.sv
// Short FIFO of classified bytes between the front end and the back end.
module scnh_queue
  import scnh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scnh_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output scnh_item_t pop_item_o
);

  scnh_item_t           mem_q [QDepth];
  logic [QAw-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QAw:0]         count_q, count_d;

  assign full_o     = (count_q == (QAw+1)'(QDepth));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QAw+1)'(push_i) - (QAw+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/scnh_back.sv
// Back end: runs both CRCs, sums the segment CRCs and holds the finished key.
module scnh_back
  import scnh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  scnh_item_t  q_item_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o  // [63:0] hash_key
);

  logic [31:0] seg_crc_q, seg_crc_d;
  logic        seg_ne_q, seg_ne_d;
  logic [31:0] seg_sum_q, seg_sum_d;
  logic [31:0] whole_crc_q, whole_crc_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] key_q;

  logic [31:0] whole_next, seg_upd, add_term, sum_next, full;

  // A last byte needs a free output register; other bytes only update state.
  assign q_pop_o = !q_empty_i && (!q_item_i.last || !out_valid_q || m_axis_tready_i);

  always_comb begin
    whole_next = crc_byte(whole_crc_q, q_item_i.name_byte);
    seg_upd    = crc_byte(seg_crc_q, q_item_i.name_byte);
    // A separator closes the open segment; a final non-separator closes the
    // segment it just extended. At most one segment closes per byte.
    if (q_item_i.sep) begin
      add_term = seg_ne_q ? ~seg_crc_q : '0;
    end else begin
      add_term = q_item_i.last ? ~seg_upd : '0;
    end
    sum_next = seg_sum_q + add_term;
    full     = ~whole_next;

    seg_crc_d   = seg_crc_q;
    seg_ne_d    = seg_ne_q;
    seg_sum_d   = seg_sum_q;
    whole_crc_d = whole_crc_q;
    if (q_pop_o) begin
      if (q_item_i.last) begin
        seg_crc_d   = CrcOnes;
        seg_ne_d    = 1'b0;
        seg_sum_d   = '0;
        whole_crc_d = CrcOnes;
      end else begin
        whole_crc_d = whole_next;
        seg_sum_d   = sum_next;
        seg_crc_d   = q_item_i.sep ? CrcOnes : seg_upd;
        seg_ne_d    = !q_item_i.sep;
      end
    end
  end

  always_comb begin
    if (q_pop_o && q_item_i.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_crc_q   <= CrcOnes;
      seg_ne_q    <= 1'b0;
      seg_sum_q   <= '0;
      whole_crc_q <= CrcOnes;
      out_valid_q <= 1'b0;
    end else begin
      seg_crc_q   <= seg_crc_d;
      seg_ne_q    <= seg_ne_d;
      seg_sum_q   <= seg_sum_d;
      whole_crc_q <= whole_crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.last) begin
      key_q <= {sum_next | KeyHiSet, full[31:16] ^ full[15:0], KeyLoTail};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = key_q;

endmodule

FILE: rtl/segmented_crc32c_name_hash.sv
// Segmented CRC-32C directory-name hash: top level.
//
// A file name enters on the slave stream one byte per transfer, with tlast on
// its final byte. The bytes '.', '-', '_' and '~' split the name into segments;
// the CRC-32C values of the non-empty segments are summed to form key bits
// 63..32, with bit 63 forced high, and the CRC-32C of the whole name folds
// into bits 31..16. One 64-bit key leaves on the master stream per name, and
// nothing else. Throughput is one byte per cycle, except that a last byte waits
// while an unaccepted key fills the output register; the back end computes
// each byte CRC update combinationally. The last byte is written into the
// four-entry queue, and the edge on which it leaves loads the key and sets tvalid.
// If the receiver stalls, the finished key waits in the output register while
// bytes of the next name keep flowing into the back end; only a further last
// byte waits, and once the queue fills, s_axis_tready_o drops.
// Reset empties the queue, drops the pending key and restarts the hash state.
module segmented_crc32c_name_hash
  import scnh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] name_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // [63:0] hash_key
);

  logic       q_full, q_push, q_pop, q_empty;
  scnh_item_t push_item, pop_item;

  scnh_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  scnh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (pop_item)
  );

  scnh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (pop_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
